// ===== rtl/wph_pkg.sv =====
// Shared constants and codes for the WAV PCM header parser.
`default_nettype none
package wph_pkg;

    // Widths of the result fields
    localparam int STATUS_W = 3;
    localparam int RATE_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 32;

    // Little-endian four-character codes
    localparam logic [WORD_W-1:0] ID_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] ID_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] ID_DATA = 32'h6174_6164;
    localparam logic [WORD_W-1:0] ID_FMT  = 32'h2074_6D66;

    localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET = 16'h8000;

    // Header layout
    localparam logic [WORD_W-1:0] HEADER_LIMIT     = 32'd128;
    localparam logic [WORD_W-1:0] FIXED_HEADER_LEN = 32'd36;
    localparam logic [5:0] OFS_RIFF  = 6'd3;
    localparam logic [5:0] OFS_WAVE  = 6'd11;
    localparam logic [5:0] OFS_FMT   = 6'd15;
    localparam logic [5:0] OFS_FMTID = 6'd23;
    localparam logic [5:0] OFS_RATE  = 6'd27;
    localparam logic [5:0] OFS_BITS  = 6'd35;

    // Chunk header byte counts
    localparam logic [2:0] HDR_ID_LAST  = 3'd3;
    localparam logic [2:0] HDR_LAST     = 3'd7;

    // Phase and status codes
    localparam logic [STATUS_W-1:0] PH_HEADER    = 3'd0;
    localparam logic [STATUS_W-1:0] PH_PLAY      = 3'd1;
    localparam logic [STATUS_W-1:0] ERR_FORMAT   = 3'd2;
    localparam logic [STATUS_W-1:0] ERR_CHANNELS = 3'd3;
    localparam logic [STATUS_W-1:0] ERR_WIDTH    = 3'd4;
    localparam logic [STATUS_W-1:0] ERR_NODATA   = 3'd5;
    localparam logic [STATUS_W-1:0] PH_DONE      = 3'd6;
    localparam logic [STATUS_W-1:0] ERR_NONE     = 3'd0;

endpackage
`default_nettype wire

// ===== rtl/wav_pcm_header_parser.sv =====
// WAV PCM header parser and sample emitter, one file byte per transaction.
//
// Input channel: i_valid / o_stall carry one file byte (i_data_byte) and a
// start marker (i_start_req) that restarts the parse on byte 0 of a file.
// Output channel: o_valid / i_stall carry one result per input byte: the
// status, the latched sample rate, the sample width flag, the data bytes
// still to play and, when o_sample_valid is high, an offset-binary sample.
// A byte accepted at a clock edge has its result on the ports after that
// edge. One byte per cycle unless i_stall holds a result; the whole update
// of the parse state is one pass of logic between the state registers and
// the output register. A result waiting under i_stall holds the output
// register and stalls the input only while it is not taken; a result taken
// in the same cycle frees the way for the next byte.
// Reset clears the parse state to header parsing and empties the output
// register; the input is stalled while reset is held. Terminal statuses
// hold until a byte with i_start_req set.
`default_nettype none
module wav_pcm_header_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [7:0]                   i_data_byte,
    input  wire                          i_start_req,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [wph_pkg::STATUS_W-1:0] o_status,
    output logic [wph_pkg::RATE_W-1:0]   o_sample_rate,
    output logic                         o_wide_samples,
    output logic [wph_pkg::WORD_W-1:0]   o_data_remaining,
    output logic                         o_sample_valid,
    output logic [wph_pkg::SAMPLE_W-1:0] o_sample
);
    import wph_pkg::*;

    // Parse state
    logic [STATUS_W-1:0] r_phase, n_phase;
    logic [WORD_W-1:0]   r_position, n_position;
    logic [WORD_W-1:0]   r_word_shift, n_word_shift;
    logic [WORD_W-1:0]   r_chunk_id, n_chunk_id;
    logic [WORD_W-1:0]   r_skip_remaining, n_skip_remaining;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic                r_width_flag, n_width_flag;
    logic [WORD_W-1:0]   r_bytes_left, n_bytes_left;
    logic [7:0]          r_low_byte, n_low_byte;
    logic                r_pair_half, n_pair_half;
    logic [STATUS_W-1:0] r_header_error, n_header_error;
    logic [2:0]          r_hdr_count, n_hdr_count;

    // Output register
    logic                r_out_valid;
    logic                n_sample_valid;
    logic [SAMPLE_W-1:0] n_sample;

    // State seen by this byte: the reset values when a new file starts
    logic [STATUS_W-1:0] s_phase;
    logic [WORD_W-1:0]   s_position, s_word_shift, s_chunk_id, s_skip_remaining;
    logic [RATE_W-1:0]   s_rate;
    logic                s_width_flag, s_pair_half;
    logic [WORD_W-1:0]   s_bytes_left;
    logic [7:0]          s_low_byte;
    logic [STATUS_W-1:0] s_header_error, v_error;
    logic [2:0]          s_hdr_count;
    logic [WORD_W-1:0]   v_bytes_dec;
    logic [15:0]         v_bits;
    logic                w_accept;

    assign o_stall  = ~i_rst_n | (r_out_valid & i_stall);
    assign w_accept = i_valid & ~o_stall;
    assign o_valid  = r_out_valid;

    // Select the starting state for this byte
    always_comb begin
        s_phase          = i_start_req ? PH_HEADER : r_phase;
        s_position       = i_start_req ? '0 : r_position;
        s_word_shift     = i_start_req ? '0 : r_word_shift;
        s_chunk_id       = i_start_req ? '0 : r_chunk_id;
        s_skip_remaining = i_start_req ? '0 : r_skip_remaining;
        s_rate           = i_start_req ? '0 : r_rate;
        s_width_flag     = i_start_req ? 1'b0 : r_width_flag;
        s_bytes_left     = i_start_req ? '0 : r_bytes_left;
        s_low_byte       = i_start_req ? '0 : r_low_byte;
        s_pair_half      = i_start_req ? 1'b0 : r_pair_half;
        s_header_error   = i_start_req ? ERR_NONE : r_header_error;
        s_hdr_count      = i_start_req ? '0 : r_hdr_count;
    end

    // Advance the parse by one byte
    always_comb begin
        n_phase          = s_phase;
        n_position       = s_position;
        n_word_shift     = s_word_shift;
        n_chunk_id       = s_chunk_id;
        n_skip_remaining = s_skip_remaining;
        n_rate           = s_rate;
        n_width_flag     = s_width_flag;
        n_bytes_left     = s_bytes_left;
        n_low_byte       = s_low_byte;
        n_pair_half      = s_pair_half;
        n_header_error   = s_header_error;
        n_hdr_count      = s_hdr_count;
        n_sample_valid   = 1'b0;
        n_sample         = '0;
        v_error          = s_header_error;
        v_bits           = '0;
        v_bytes_dec      = s_bytes_left - 32'd1;

        unique case (s_phase)
            PH_HEADER: begin
                n_word_shift = {i_data_byte, s_word_shift[WORD_W-1:8]};
                if (s_position != '1) begin
                    n_position = s_position + 32'd1;
                end
                if (s_position < FIXED_HEADER_LEN) begin
                    // Fixed RIFF and fmt fields
                    unique case (s_position[5:0])
                        OFS_RIFF: begin
                            if (n_word_shift != ID_RIFF && s_header_error == ERR_NONE) begin
                                n_header_error = ERR_FORMAT;
                            end
                        end
                        OFS_WAVE: begin
                            if (n_word_shift != ID_WAVE && s_header_error == ERR_NONE) begin
                                n_header_error = ERR_FORMAT;
                            end
                        end
                        OFS_FMT: begin
                            if (n_word_shift != ID_FMT && s_header_error == ERR_NONE) begin
                                n_header_error = ERR_FORMAT;
                            end
                        end
                        OFS_FMTID: begin
                            if (s_header_error == ERR_NONE) begin
                                if (n_word_shift[15:0] != 16'd1) begin
                                    n_header_error = ERR_FORMAT;
                                end else if (n_word_shift[31:16] > 16'd1) begin
                                    n_header_error = ERR_CHANNELS;
                                end
                            end
                        end
                        OFS_RATE: begin
                            n_rate = n_word_shift[RATE_W-1:0];
                        end
                        OFS_BITS: begin
                            v_bits = n_word_shift[31:16];
                            if (v_bits != 16'd8 && v_bits != 16'd16
                                && s_header_error == ERR_NONE) begin
                                v_error = ERR_WIDTH;
                            end
                            n_header_error = v_error;
                            if (v_error != ERR_NONE) begin
                                n_phase = v_error;
                            end else begin
                                n_width_flag = (v_bits == 16'd16);
                            end
                        end
                        default: ;
                    endcase
                end else if (s_skip_remaining != '0) begin
                    // Drop the body of a skipped chunk
                    n_skip_remaining = s_skip_remaining - 32'd1;
                end else begin
                    // Chunk header: id then size
                    n_hdr_count = s_hdr_count + 3'd1;
                    if (s_hdr_count == HDR_ID_LAST) begin
                        n_chunk_id = n_word_shift;
                    end
                    if (s_hdr_count == HDR_LAST) begin
                        n_hdr_count = '0;
                        if (s_chunk_id == ID_DATA) begin
                            n_bytes_left = n_word_shift;
                            n_pair_half  = 1'b0;
                            n_phase      = (n_word_shift != '0) ? PH_PLAY : PH_DONE;
                        end else if (n_position > HEADER_LIMIT) begin
                            n_phase = ERR_NODATA;
                        end else begin
                            n_skip_remaining = n_word_shift;
                        end
                    end
                end
            end
            PH_PLAY: begin
                n_bytes_left = v_bytes_dec;
                if (!s_width_flag) begin
                    n_sample       = {8'h00, i_data_byte};
                    n_sample_valid = 1'b1;
                end else if (!s_pair_half) begin
                    n_low_byte  = i_data_byte;
                    n_pair_half = 1'b1;
                    if (v_bytes_dec == '0) begin
                        // Lone last byte of an odd-length wide stream
                        n_sample       = {8'h00, i_data_byte} + SAMPLE_OFFSET;
                        n_sample_valid = 1'b1;
                        n_pair_half    = 1'b0;
                    end
                end else begin
                    n_sample       = {i_data_byte, s_low_byte} + SAMPLE_OFFSET;
                    n_sample_valid = 1'b1;
                    n_pair_half    = 1'b0;
                end
                if (v_bytes_dec == '0) begin
                    n_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // Hold or load the parse state and the output flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_position       <= '0;
            r_word_shift     <= '0;
            r_chunk_id       <= '0;
            r_skip_remaining <= '0;
            r_rate           <= '0;
            r_width_flag     <= 1'b0;
            r_bytes_left     <= '0;
            r_low_byte       <= '0;
            r_pair_half      <= 1'b0;
            r_header_error   <= ERR_NONE;
            r_hdr_count      <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase          <= n_phase;
                r_position       <= n_position;
                r_word_shift     <= n_word_shift;
                r_chunk_id       <= n_chunk_id;
                r_skip_remaining <= n_skip_remaining;
                r_rate           <= n_rate;
                r_width_flag     <= n_width_flag;
                r_bytes_left     <= n_bytes_left;
                r_low_byte       <= n_low_byte;
                r_pair_half      <= n_pair_half;
                r_header_error   <= n_header_error;
                r_hdr_count      <= n_hdr_count;
                r_out_valid      <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload with each accepted transaction
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            o_status         <= n_phase;
            o_sample_rate    <= n_rate;
            o_wide_samples   <= n_width_flag;
            o_data_remaining <= n_bytes_left;
            o_sample_valid   <= n_sample_valid;
            o_sample         <= n_sample;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the WAV PCM header parser: byte streams in, checked results out.
`timescale 1ns / 100ps

import wph_pkg::*;

// One expected or observed result of the parser
typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RATE_W-1:0]   rate;
    logic                wide;
    logic [WORD_W-1:0]   remaining;
    logic                smp_valid;
    logic [SAMPLE_W-1:0] smp;
} t_parse_out;

// One byte of a file stream with its start-of-file marker
typedef struct packed {
    logic [7:0] b;
    logic       s;
} t_file_byte;

localparam logic [15:0] PCM_FORMAT  = 16'd1;
localparam logic [15:0] BITS_NARROW = 16'd8;
localparam logic [15:0] BITS_WIDE   = 16'd16;

// Tracks the parse of the byte stream and checks every result against it
class wav_parse_tracker;
    logic [STATUS_W-1:0] phase;
    logic [WORD_W-1:0]   position;
    logic [WORD_W-1:0]   word_shift;
    logic [WORD_W-1:0]   chunk_id;
    logic [WORD_W-1:0]   skip_left;
    logic [RATE_W-1:0]   rate;
    logic                wide;
    logic [WORD_W-1:0]   bytes_left;
    logic [7:0]          low_byte;
    logic                pair_half;
    logic [STATUS_W-1:0] hdr_err;
    logic [2:0]          hdr_count;
    t_parse_out          due_q[$];
    int                  mismatches;
    int                  seen_bytes;

    function new();
        clear_state();
        mismatches = 0;
        seen_bytes = 0;
    endfunction

    function void clear_state();
        phase      = PH_HEADER;
        position   = '0;
        word_shift = '0;
        chunk_id   = '0;
        skip_left  = '0;
        rate       = '0;
        wide       = 1'b0;
        bytes_left = '0;
        low_byte   = '0;
        pair_half  = 1'b0;
        hdr_err    = ERR_NONE;
        hdr_count  = '0;
    endfunction

    // Keep only the first header fault
    function void raise_error(logic [STATUS_W-1:0] code);
        if (hdr_err == ERR_NONE) begin
            hdr_err = code;
        end
    endfunction

    // Advance the parse by one accepted byte and queue the result it causes
    function void note_byte(logic [7:0] b, logic restart);
        logic [WORD_W-1:0] pos;
        logic [15:0]       bits;
        t_parse_out        r;
        r = '0;
        seen_bytes++;
        if (restart) begin
            clear_state();
        end
        if (phase == PH_HEADER) begin
            pos = position;
            word_shift = {b, word_shift[WORD_W-1:8]};
            if (position != '1) begin
                position++;
            end
            if (pos < FIXED_HEADER_LEN) begin
                // Check the fixed RIFF and fmt fields as their last byte arrives
                case (pos[5:0])
                    OFS_RIFF: begin
                        if (word_shift != ID_RIFF) raise_error(ERR_FORMAT);
                    end
                    OFS_WAVE: begin
                        if (word_shift != ID_WAVE) raise_error(ERR_FORMAT);
                    end
                    OFS_FMT: begin
                        if (word_shift != ID_FMT) raise_error(ERR_FORMAT);
                    end
                    OFS_FMTID: begin
                        if (word_shift[15:0] != PCM_FORMAT) raise_error(ERR_FORMAT);
                        else if (word_shift[31:16] > 16'd1) raise_error(ERR_CHANNELS);
                    end
                    OFS_RATE: begin
                        rate = word_shift[15:0];
                    end
                    OFS_BITS: begin
                        bits = word_shift[31:16];
                        if (bits != BITS_NARROW && bits != BITS_WIDE) raise_error(ERR_WIDTH);
                        if (hdr_err != ERR_NONE) phase = hdr_err;
                        else wide = (bits == BITS_WIDE);
                    end
                    default: ;
                endcase
            end else if (skip_left != '0) begin
                skip_left--;
            end else begin
                // Collect an 8-byte chunk header: id then size
                if (hdr_count == HDR_ID_LAST) begin
                    chunk_id = word_shift;
                end
                if (hdr_count == HDR_LAST) begin
                    hdr_count = '0;
                    if (chunk_id == ID_DATA) begin
                        bytes_left = word_shift;
                        pair_half  = 1'b0;
                        phase      = (word_shift != '0) ? PH_PLAY : PH_DONE;
                    end else if (position > HEADER_LIMIT) begin
                        phase = ERR_NODATA;
                    end else begin
                        skip_left = word_shift;
                    end
                end else begin
                    hdr_count++;
                end
            end
        end else if (phase == PH_PLAY) begin
            bytes_left--;
            if (!wide) begin
                r.smp       = {8'h00, b};
                r.smp_valid = 1'b1;
            end else if (!pair_half) begin
                low_byte  = b;
                pair_half = 1'b1;
                // A lone last byte goes out with a zero high byte
                if (bytes_left == '0) begin
                    r.smp       = {8'h00, low_byte} + SAMPLE_OFFSET;
                    r.smp_valid = 1'b1;
                    pair_half   = 1'b0;
                end
            end else begin
                r.smp       = {b, low_byte} + SAMPLE_OFFSET;
                r.smp_valid = 1'b1;
                pair_half   = 1'b0;
            end
            if (bytes_left == '0) begin
                phase = PH_DONE;
            end
        end
        r.status    = phase;
        r.rate      = rate;
        r.wide      = wide;
        r.remaining = bytes_left;
        due_q.push_back(r);
    endfunction

    function bit field_differs(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
        if (want === got) begin
            return 1'b0;
        end
        if (mismatches < 10) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
        return 1'b1;
    endfunction

    // Compare one taken result with the oldest one still awaited
    function void check_result(t_parse_out got);
        t_parse_out want;
        bit         bad;
        if (due_q.size() == 0) begin
            if (mismatches < 10) begin
                $display("%0t: result with none awaited, status %0d", $time, got.status);
            end
            mismatches++;
            return;
        end
        want = due_q.pop_front();
        bad = 1'b0;
        bad |= field_differs("status", 32'(want.status), 32'(got.status));
        bad |= field_differs("sample_rate", 32'(want.rate), 32'(got.rate));
        bad |= field_differs("wide_samples", 32'(want.wide), 32'(got.wide));
        bad |= field_differs("data_remaining", want.remaining, got.remaining);
        bad |= field_differs("sample_valid", 32'(want.smp_valid), 32'(got.smp_valid));
        bad |= field_differs("sample", 32'(want.smp), 32'(got.smp));
        if (bad) begin
            mismatches++;
        end
    endfunction

    function int pending();
        return due_q.size();
    endfunction
endclass

module tb;
    localparam int STALE_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [7:0]          i_data_byte = '0;
    logic                i_start_req = 1'b0;
    logic                i_stall     = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [RATE_W-1:0]   o_sample_rate;
    logic                o_wide_samples;
    logic [WORD_W-1:0]   o_data_remaining;
    logic                o_sample_valid;
    logic [SAMPLE_W-1:0] o_sample;

    wav_parse_tracker sb = new();
    t_file_byte       stream_q[$];
    int               idle_pct  = 0;
    int               stall_pct = 0;
    logic             hold_on   = 1'b0;
    event             hold_start;

    wav_pcm_header_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_start_req      (i_start_req),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_sample_rate    (o_sample_rate),
        .o_wide_samples   (o_wide_samples),
        .o_data_remaining (o_data_remaining),
        .o_sample_valid   (o_sample_valid),
        .o_sample         (o_sample)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hold the receiver off for a long stretch once asked
    initial begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Take results, then decide the stall for the next cycle
    always @(posedge i_clk) begin
        t_parse_out seen;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = '{status: o_status, rate: o_sample_rate, wide: o_wide_samples,
                     remaining: o_data_remaining, smp_valid: o_sample_valid,
                     smp: o_sample};
            sb.check_result(seen);
        end
        i_stall <= hold_on | ($urandom_range(99) < stall_pct);
    end

    // Abort when neither side moves a transaction for too long
    initial begin
        int stale;
        stale = 0;
        while (stale < STALE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stale = 0;
            else stale++;
        end
        $display("** wav_pcm_header_parser: FAILED **");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b, input logic s);
        stream_q.push_back('{b: b, s: s});
    endtask

    task automatic put_half(input logic [15:0] h);
        put_byte(h[7:0], 1'b0);
        put_byte(h[15:8], 1'b0);
    endtask

    task automatic put_word(input logic [31:0] w, input logic s);
        put_byte(w[7:0], s);
        put_byte(w[15:8], 1'b0);
        put_byte(w[23:16], 1'b0);
        put_byte(w[31:24], 1'b0);
    endtask

    task automatic put_noise(input int n, input int start_pct);
        repeat (n) put_byte(8'($urandom), $urandom_range(99) < start_pct);
    endtask

    // Queue the 36-byte RIFF and fmt header, first byte marked as a new file
    task automatic put_fmt_header(input logic [31:0] riff, input logic [31:0] wave,
                                  input logic [31:0] fmt_id, input logic [15:0] code,
                                  input logic [15:0] chans, input logic [31:0] rate,
                                  input logic [15:0] bits);
        put_word(riff, 1'b1);
        put_word($urandom, 1'b0);
        put_word(wave, 1'b0);
        put_word(fmt_id, 1'b0);
        put_word(32'd16, 1'b0);
        put_half(code);
        put_half(chans);
        put_word(rate, 1'b0);
        put_word($urandom, 1'b0);
        put_half(16'($urandom));
        put_half(bits);
    endtask

    task automatic put_chunk(input logic [31:0] id, input logic [31:0] size, input int body);
        put_word(id, 1'b0);
        put_word(size, 1'b0);
        put_noise(body, 0);
    endtask

    function automatic logic [31:0] other_id();
        logic [31:0] w;
        w = $urandom;
        if (w == ID_DATA) w ^= 32'd1;
        return w;
    endfunction

    // Offer queued bytes one transaction at a time, idling at random
    task automatic send_stream();
        t_file_byte item;
        while (stream_q.size() != 0) begin
            item = stream_q.pop_front();
            while ($urandom_range(99) < idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= item.b;
            i_start_req <= item.s;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            sb.note_byte(item.b, item.s);
        end
    endtask

    // Hold off the sender until every awaited result has come
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Queue one file: mostly well formed, sometimes with a faulty field
    task automatic queue_random_file();
        logic [31:0] riff, wave, fmt_id, dlen;
        logic [15:0] code, chans, bits;
        int          size, sent, kind;
        riff   = ID_RIFF;
        wave   = ID_WAVE;
        fmt_id = ID_FMT;
        if ($urandom_range(19) == 0) riff ^= 32'd1 << $urandom_range(31);
        if ($urandom_range(19) == 0) wave ^= 32'd1 << $urandom_range(31);
        if ($urandom_range(19) == 0) fmt_id ^= 32'd1 << $urandom_range(31);
        code  = ($urandom_range(19) == 0) ? 16'($urandom) : PCM_FORMAT;
        chans = ($urandom_range(14) == 0) ? 16'($urandom) : 16'($urandom_range(1));
        bits  = $urandom_range(1) ? BITS_WIDE : BITS_NARROW;
        if ($urandom_range(14) == 0) bits = 16'($urandom);
        put_fmt_header(riff, wave, fmt_id, code, chans, $urandom, bits);
        repeat ($urandom_range(2)) begin
            size = $urandom_range(12);
            put_chunk(other_id(), size, size);
        end
        kind = $urandom_range(19);
        if (kind == 0) begin
            // Only foreign chunks: runs past the header limit
            repeat (10) put_chunk(other_id(), 4, 4);
        end else if (kind == 1) begin
            // Enormous foreign chunk, cut short by the next file
            put_chunk(other_id(), $urandom | 32'h8000_0000, $urandom_range(24));
        end else begin
            dlen = ($urandom_range(9) == 0) ? 32'($urandom) : 32'($urandom_range(48));
            sent = (dlen > 60) ? $urandom_range(60) : int'(dlen);
            if ($urandom_range(9) == 0 && sent > 0) sent = $urandom_range(sent - 1);
            put_chunk(ID_DATA, dlen, sent);
            put_noise($urandom_range(3), 0);
        end
    endtask

    initial begin
        int file_no;
        int stage;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 8-bit mono-less file (zero channels), extreme bytes, trailing bytes ignored
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd0, 32'hFFFF_FFFF, BITS_NARROW);
        put_chunk(ID_DATA, 3, 0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h80, 1'b0);
        put_noise(2, 0);
        // 16-bit file with an odd data length
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, 32'd0, BITS_WIDE);
        put_chunk(ID_DATA, 5, 0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b0);
        // Empty data chunk
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, 32'd44100, BITS_NARROW);
        put_chunk(ID_DATA, 0, 1);
        // Each header fault, plus combined faults where the earliest check wins
        put_fmt_header(~ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_fmt_header(ID_RIFF, ID_DATA, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_DATA, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, 16'hFFFF, 16'd1, $urandom, BITS_WIDE);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd2, $urandom, BITS_WIDE);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'hFFFF, $urandom, 16'd24);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd0, $urandom, 16'd0);
        put_fmt_header(ID_WAVE, ID_WAVE, ID_FMT, 16'd3, 16'd5, $urandom, 16'hFFFF);
        put_noise(1, 0);
        // Foreign header ending exactly at the limit still lets data through
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_NARROW);
        put_chunk(other_id(), 76, 76);
        put_chunk(other_id(), 0, 0);
        put_chunk(ID_DATA, 2, 2);
        // One byte further and the data chunk is never reached
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_chunk(other_id(), 77, 77);
        put_chunk(other_id(), 0, 0);
        put_chunk(ID_DATA, 2, 3);
        // Maximal skip, then a restart while still skipping
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd0, $urandom, BITS_WIDE);
        put_chunk(other_id(), 32'hFFFF_FFFF, 20);
        // Maximal data size, restarted while playing
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_chunk(ID_DATA, 32'hFFFF_FFFF, 7);
        put_fmt_header(ID_RIFF, ID_WAVE, ID_FMT, PCM_FORMAT, 16'd1, $urandom, BITS_WIDE);
        put_chunk(ID_DATA, 4, 4);
        send_stream();

        // Random files, one idling mix per file in rotation
        file_no = 0;
        while (sb.seen_bytes < 1300 || file_no < 4) begin
            drain();
            stage = file_no % 4;
            idle_pct  = (stage == 1) ? 57 : (stage == 3) ? 24 : 0;
            stall_pct = (stage == 2) ? 57 : (stage == 3) ? 24 : 0;
            // Block the output long enough to back up the input
            if (file_no == 2) -> hold_start;
            if ($urandom_range(9) == 0) put_noise($urandom_range(1, 20), 10);
            else queue_random_file();
            send_stream();
            file_no++;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** wav_pcm_header_parser: PASSED **");
        end else begin
            $display("** wav_pcm_header_parser: FAILED **");
        end
        $finish;
    end
endmodule
